// ===== design/slsi_pkg.sv =====
package slsi_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } command_t;

  typedef struct packed {
    command_t                   command;
    logic signed [VALUE_W-1:0]  value;
  } request_t;

  typedef struct packed {
    logic                ok;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic                is_full;
  } result_t;

  // Compare flags one cell produces; le feeds its right neighbor
  typedef struct packed {
    logic le;   // occupied and entry <= value
    logic lt;   // occupied and entry <  value
    logic eq;   // occupied and entry == value
  } cell_flags_t;

endpackage

// ===== design/slsi_cell.sv =====
module slsi_cell (
  input  logic                                 clk,
  input  logic                                 update,
  input  slsi_pkg::command_t                   command,
  input  logic signed [slsi_pkg::VALUE_W-1:0]  value,
  input  logic                                 occupied,
  input  logic                                 left_le,
  input  logic signed [slsi_pkg::VALUE_W-1:0]  left_entry,
  input  logic signed [slsi_pkg::VALUE_W-1:0]  right_entry,
  output logic signed [slsi_pkg::VALUE_W-1:0]  entry,
  output slsi_pkg::cell_flags_t                flags
);

  logic signed [slsi_pkg::VALUE_W-1:0] entry_next;

  assign flags.le = occupied && (entry <= value);
  assign flags.lt = occupied && (entry < value);
  assign flags.eq = occupied && (entry == value);

  always_comb begin
    case (command)
      slsi_pkg::CMD_INSERT: begin
        // keep, take the new value, or take the left neighbor's entry
        if (flags.le) begin
          entry_next = entry;
        end else if (left_le) begin
          entry_next = value;
        end else begin
          entry_next = left_entry;
        end
      end
      slsi_pkg::CMD_REMOVE: begin
        // keep below the hole, pull from the right at and above it
        entry_next = flags.lt ? entry : right_entry;
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (update) begin
      entry <= entry_next;
    end
  end

endmodule

// ===== design/sorted_list_insert_remove_unit.sv =====
// Sorted list of up to DEPTH signed 32-bit values kept in ascending order in a
// row of compare-and-shift cells. Pulse start with a request (insert or remove
// one occurrence of a value); busy is always low, so a request may be issued
// in every cycle. The result (ok, count, is_empty, is_full) appears on result
// with done high for exactly one cycle, the cycle after the request is taken;
// the receiver cannot stall it, so capture it then. Every cell compares its
// entry with the request value in parallel and takes its new entry from itself,
// the request or a neighbor, so the cost of a request does not depend on the fill.
// An insert goes after all equal entries and fails when the list is full; a
// remove deletes the first equal entry and fails when the value is absent.
// count is the entry count truncated to five bits. No clearing pass is needed
// after reset: only cells below the count are ever looked at.
module sorted_list_insert_remove_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  slsi_pkg::request_t  request,
  output logic                done,
  output slsi_pkg::result_t   result
);

  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  logic signed [slsi_pkg::VALUE_W-1:0] entries [DEPTH];
  slsi_pkg::cell_flags_t               flags   [DEPTH];
  logic [DEPTH-1:0]                    occupied;
  logic [DEPTH-1:0]                    eq_vec;

  logic accept;
  logic full;
  logic found;
  logic ok;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (fill >= FILL_MAX);
  assign found  = |eq_vec;

  // Decide success from the current fill and the cells' compare flags
  always_comb begin
    case (request.command)
      slsi_pkg::CMD_INSERT: ok = !full;
      slsi_pkg::CMD_REMOVE: ok = found;
      default:              ok = 1'b0;
    endcase
  end

  always_comb begin
    fill_next = fill;
    if (accept && ok) begin
      if (request.command == slsi_pkg::CMD_INSERT) begin
        fill_next = fill + FILL_W'(1);
      end else begin
        fill_next = fill - FILL_W'(1);
      end
    end
  end

  // Build the cell row; the ends see tied-off neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [FILL_W-1:0] IDX = FILL_W'(i);
    logic                                left_le;
    logic signed [slsi_pkg::VALUE_W-1:0] left_entry;
    logic signed [slsi_pkg::VALUE_W-1:0] right_entry;

    assign occupied[i] = (IDX < fill);
    assign eq_vec[i]   = flags[i].eq;

    if (i == 0) begin : g_first
      // everything left of the head counts as <= value
      assign left_le    = 1'b1;
      assign left_entry = request.value;
    end else begin : g_mid
      assign left_le    = flags[i-1].le;
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      // the tail drops out of range on a remove, so hold it
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    slsi_cell u_cell (
      .clk         (clk),
      .update      (accept && ok),
      .command     (request.command),
      .value       (request.value),
      .occupied    (occupied[i]),
      .left_le     (left_le),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .flags       (flags[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      done <= 1'b0;
    end else begin
      fill <= fill_next;
      done <= accept;
    end
  end

  // Result payload: hold until the next item overwrites it
  always_ff @(posedge clk) begin
    if (accept) begin
      result.ok       <= ok;
      result.count    <= slsi_pkg::COUNT_W'(fill_next);
      result.is_empty <= (fill_next == '0);
      result.is_full  <= (fill_next >= FILL_MAX);
    end
  end

  // Fill never passes the capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("fill exceeds DEPTH");

  // Every accepted item yields exactly one result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted item produced no result");

  // An insert into a full list fails and leaves the fill alone
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (accept && full && (request.command == slsi_pkg::CMD_INSERT))
      |=> (done && !result.ok && (fill == $past(fill))))
    else $error("insert into full list changed the list");

  // Occupied cells stay in ascending order
  for (genvar k = 1; k < DEPTH; k++) begin : g_sorted_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      occupied[k] |-> (entries[k-1] <= entries[k]))
      else $error("list out of order");
  end

endmodule

// ===== tb/tb_sorted_list_insert_remove_unit.sv =====
`timescale 1ns / 1ps

module tb_sorted_list_insert_remove_unit;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned SLOT_W     = $clog2(LIST_DEPTH);
  localparam logic signed [slsi_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [slsi_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  slsi_pkg::request_t request;
  logic               done;
  slsi_pkg::result_t  result;

  // Shadow copy of the list: ascending entries, only slots below list_fill are valid
  logic signed [slsi_pkg::VALUE_W-1:0] list_slots [LIST_DEPTH];
  int unsigned                         list_fill;

  // Results still owed by the block, oldest first
  slsi_pkg::result_t expected_results [$];
  int                mismatches;
  // Set to run a stretch of back-to-back items with no idle cycles
  bit                back_to_back;

  sorted_list_insert_remove_unit #(
    .DEPTH(LIST_DEPTH)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block stops answering
  initial begin
    #500_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Apply one accepted item to the shadow list and return the result it must produce
  function automatic slsi_pkg::result_t apply_request(slsi_pkg::request_t req);
    logic signed [slsi_pkg::VALUE_W-1:0] v;
    int unsigned                         pos;
    logic                                ok;
    slsi_pkg::result_t                   res;
    v   = req.value;
    pos = 0;
    ok  = 1'b0;
    if (req.command == slsi_pkg::CMD_INSERT) begin
      if (list_fill < LIST_DEPTH) begin
        // Skip every entry <= value so the new one lands after its duplicates
        while (pos < list_fill && list_slots[SLOT_W'(pos)] <= v) pos++;
        for (int unsigned i = list_fill; i > pos; i--) begin
          list_slots[SLOT_W'(i)] = list_slots[SLOT_W'(i - 1)];
        end
        list_slots[SLOT_W'(pos)] = v;
        list_fill++;
        ok = 1'b1;
      end
    end else begin
      if (list_fill != 0) begin
        // First entry not below value is the lowest matching one, if any
        while (pos < list_fill && list_slots[SLOT_W'(pos)] < v) pos++;
        if (pos < list_fill && list_slots[SLOT_W'(pos)] == v) begin
          for (int unsigned i = pos + 1; i < list_fill; i++) begin
            list_slots[SLOT_W'(i - 1)] = list_slots[SLOT_W'(i)];
          end
          list_fill--;
          ok = 1'b1;
        end
      end
    end
    res.ok       = ok;
    res.count    = list_fill[slsi_pkg::COUNT_W-1:0];
    res.is_empty = (list_fill == 0);
    res.is_full  = (list_fill >= LIST_DEPTH);
    return res;
  endfunction

  task automatic compare_field(string field, logic [slsi_pkg::COUNT_W-1:0] want,
                               logic [slsi_pkg::COUNT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  // Match every strobed result against the oldest outstanding expectation
  always @(posedge clk) begin
    slsi_pkg::result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual %p", $time, result);
      end else begin
        want = expected_results.pop_front();
        compare_field("ok", slsi_pkg::COUNT_W'(want.ok), slsi_pkg::COUNT_W'(result.ok));
        compare_field("count", want.count, result.count);
        compare_field("is_empty", slsi_pkg::COUNT_W'(want.is_empty),
                      slsi_pkg::COUNT_W'(result.is_empty));
        compare_field("is_full", slsi_pkg::COUNT_W'(want.is_full),
                      slsi_pkg::COUNT_W'(result.is_full));
      end
    end
  end

  // Idle a random number of cycles, present one item, hold it until taken
  task automatic send_item(slsi_pkg::command_t cmd, logic signed [slsi_pkg::VALUE_W-1:0] val);
    int unsigned        gap;
    slsi_pkg::request_t req;
    gap = back_to_back ? 0 : $urandom_range(0, 10);
    req.command = cmd;
    req.value   = val;
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   = 1'b1;
    request = req;
    do @(posedge clk); while (busy !== 1'b0);
    expected_results.push_back(apply_request(req));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_until_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Mostly small values so removes find matches and duplicates pile up
  function automatic logic signed [slsi_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0:       return VALUE_MIN;
          1:       return VALUE_MAX;
          2:       return 0;
          default: return -1;
        endcase
      end
      default: return int'($urandom_range(0, 6)) - 3;
    endcase
  endfunction

  // Draw a random item; removes usually target a value that is held
  task automatic send_random_item(int unsigned insert_pct);
    logic signed [slsi_pkg::VALUE_W-1:0] val;
    if ($urandom_range(0, 99) < insert_pct) begin
      send_item(slsi_pkg::CMD_INSERT, pick_value());
    end else begin
      if (list_fill != 0 && $urandom_range(0, 99) < 60) begin
        val = list_slots[SLOT_W'($urandom_range(0, list_fill - 1))];
      end else begin
        val = pick_value();
      end
      send_item(slsi_pkg::CMD_REMOVE, val);
    end
  endtask

  // Removes on an empty list must fail and leave the count at zero
  task automatic test_empty_list();
    send_item(slsi_pkg::CMD_REMOVE, 0);
    send_item(slsi_pkg::CMD_REMOVE, VALUE_MIN);
  endtask

  // Extreme values, a duplicate pair, an absent value and removal of duplicates
  task automatic test_extremes_and_duplicates();
    send_item(slsi_pkg::CMD_INSERT, VALUE_MIN);
    send_item(slsi_pkg::CMD_INSERT, VALUE_MAX);
    send_item(slsi_pkg::CMD_INSERT, 7);
    send_item(slsi_pkg::CMD_INSERT, 7);
    send_item(slsi_pkg::CMD_INSERT, -1);
    send_item(slsi_pkg::CMD_REMOVE, 8);
    send_item(slsi_pkg::CMD_REMOVE, 7);
    send_item(slsi_pkg::CMD_REMOVE, 7);
    send_item(slsi_pkg::CMD_REMOVE, 7);
  endtask

  // Fill up with descending values, hit the full limit, then free one slot
  task automatic test_full_list();
    for (int k = 0; k < 13; k++) send_item(slsi_pkg::CMD_INSERT, 100 - 16 * k);
    send_item(slsi_pkg::CMD_INSERT, 5);
    send_item(slsi_pkg::CMD_REMOVE, VALUE_MAX);
  endtask

  // Hold off the sender until the block has answered everything, then resume
  task automatic test_pause_until_drained();
    back_to_back = 1'b1;
    repeat (20) send_random_item(50);
    back_to_back = 1'b0;
    stop_sending();
    wait_until_drained();
    repeat (20) send_random_item(50);
  endtask

  // Blocks with different insert bias so the list swings between empty and full
  task automatic test_random_traffic();
    int unsigned bias [8] = '{85, 20, 90, 50, 10, 75, 30, 60};
    for (int b = 0; b < 8; b++) begin
      back_to_back = ($urandom_range(0, 2) == 0);
      repeat (95) send_random_item(bias[3'(b)]);
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    mismatches   = 0;
    list_fill    = 0;
    back_to_back = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_extremes_and_duplicates();
    test_full_list();
    test_pause_until_drained();
    test_random_traffic();

    stop_sending();
    wait_until_drained();
    // Give a stray late result a chance to show up
    repeat (5) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
